// File: rtl/rph_pkg.sv
// rph_pkg: widths, register codes, reset values and constants for the ray panel hit test
// depends on nothing; used by rph_pix_div, ray_panel_hit_test and the testbench
package rph_pkg;

  localparam int PIX_W   = 12;
  localparam int REG_W   = 48;
  localparam int Q88_W   = 16;
  localparam int HALF_W  = 16;
  localparam int IDX_W   = 3;

  // dot products: direction terms and offset terms
  localparam int DD_W    = 34;
  localparam int OTP_W   = 17;
  localparam int PO_W    = 33;
  localparam int DO_W    = 35;
  localparam int NUM_W   = 36;

  // distance divider
  localparam int Q_W     = 22;
  localparam int NEGN_W  = 33;
  localparam int NUMER_W = NEGN_W + 14;
  localparam int DEN_W   = 32;
  localparam int CMP_W   = Q_W + DEN_W;

  // projection and pixel mapping
  localparam int PROD_W  = DD_W + Q_W + 1;
  localparam int AH_W    = 45;
  localparam int H22_W   = HALF_W + 14;
  localparam int N_W     = 60;
  localparam int MAG_W   = N_W - 15;
  localparam int PREM_W  = HALF_W + PIX_W;
  localparam int PIX_LAT = PIX_W + 1;

  localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_UP     = 3'd1;
  localparam logic [IDX_W-1:0] REG_NORMAL = 3'd2;
  localparam logic [IDX_W-1:0] REG_PIVOT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIST   = 3'd4;
  localparam logic [IDX_W-1:0] REG_HALF_W = 3'd5;
  localparam logic [IDX_W-1:0] REG_HALF_H = 3'd6;
  localparam logic [IDX_W-1:0] REG_WINDOW = 3'd7;

  localparam logic [REG_W-1:0] RIGHT_RST  = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] UP_RST     = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] NORMAL_RST = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0] PIVOT_RST  = 48'h0;
  localparam logic [Q88_W-1:0] DIST_RST   = 16'd768;
  localparam logic [Q88_W-1:0] HALF_W_RST = 16'd512;
  localparam logic [Q88_W-1:0] HALF_H_RST = 16'd384;
  localparam logic [REG_W-1:0] WINDOW_RST = 48'h1E0_280_000_000;

  // cos 100 degrees in Q.28
  localparam logic signed [DD_W-1:0] COS100 = -34'sd46613280;

endpackage

// File: rtl/ray_panel_hit_test.sv
// ray_panel_hit_test: ray against a configured flat panel, result pixel and distance
// one item per cycle sustained while no result is held
// stages: 3 for offsets, products and dot sums, 22 for the distance divider,
// 3 for projection and scaling, 13 for the pixel dividers, 1 output register
// a held result stalls the whole pipeline; synchronous reset clears valids
// and sets config to its reset values; depends on rph_pkg and rph_pix_div
module ray_panel_hit_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 origin_x,
  input  logic signed [15:0]                 origin_y,
  input  logic signed [15:0]                 origin_z,
  input  logic signed [15:0]                 dir_x,
  input  logic signed [15:0]                 dir_y,
  input  logic signed [15:0]                 dir_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic [rph_pkg::PIX_W-1:0]          pixel_x,
  output logic [rph_pkg::PIX_W-1:0]          pixel_y,
  output logic [15:0]                        hit_distance,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rph_pkg::IDX_W-1:0]          cfg_index,
  input  logic [rph_pkg::REG_W-1:0]          cfg_data
);

  logic [rph_pkg::REG_W-1:0] right_axis, up_axis, normal_axis, pivot_point, visible_window;
  logic [rph_pkg::Q88_W-1:0] panel_distance, half_width, half_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      right_axis     <= rph_pkg::RIGHT_RST;
      up_axis        <= rph_pkg::UP_RST;
      normal_axis    <= rph_pkg::NORMAL_RST;
      pivot_point    <= rph_pkg::PIVOT_RST;
      panel_distance <= rph_pkg::DIST_RST;
      half_width     <= rph_pkg::HALF_W_RST;
      half_height    <= rph_pkg::HALF_H_RST;
      visible_window <= rph_pkg::WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rph_pkg::REG_RIGHT:  right_axis     <= cfg_data;
        rph_pkg::REG_UP:     up_axis        <= cfg_data;
        rph_pkg::REG_NORMAL: normal_axis    <= cfg_data;
        rph_pkg::REG_PIVOT:  pivot_point    <= cfg_data;
        rph_pkg::REG_DIST:   panel_distance <= cfg_data[rph_pkg::Q88_W-1:0];
        rph_pkg::REG_HALF_W: half_width     <= cfg_data[rph_pkg::Q88_W-1:0];
        rph_pkg::REG_HALF_H: half_height    <= cfg_data[rph_pkg::Q88_W-1:0];
        rph_pkg::REG_WINDOW: visible_window <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] rx [3];
  logic signed [15:0] uy [3];
  logic signed [15:0] nz [3];
  logic signed [15:0] piv [3];
  logic signed [15:0] org [3];
  logic signed [15:0] dir [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rx[i]  = right_axis[16*i +: 16];
      uy[i]  = up_axis[16*i +: 16];
      nz[i]  = normal_axis[16*i +: 16];
      piv[i] = pivot_point[16*i +: 16];
    end
    org[0] = origin_x;
    org[1] = origin_y;
    org[2] = origin_z;
    dir[0] = dir_x;
    dir[1] = dir_y;
    dir[2] = dir_z;
  end

  logic [rph_pkg::PIX_W-1:0] win_x, win_y, win_w, win_h;
  logic [rph_pkg::H22_W-1:0] h22_x, h22_y;

  assign win_x = visible_window[0 +: rph_pkg::PIX_W];
  assign win_y = visible_window[rph_pkg::PIX_W +: rph_pkg::PIX_W];
  assign win_w = visible_window[2*rph_pkg::PIX_W +: rph_pkg::PIX_W];
  assign win_h = visible_window[3*rph_pkg::PIX_W +: rph_pkg::PIX_W];
  assign h22_x = {half_width, 14'b0};
  assign h22_y = {half_height, 14'b0};

  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // stage 1: pivot to origin offset
  logic                           s1_v;
  logic signed [15:0]             s1_dir [3];
  logic signed [rph_pkg::OTP_W-1:0] s1_otp [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (advance) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s1_dir[i] <= dir[i];
        s1_otp[i] <= {piv[i][15], piv[i]} - {org[i][15], org[i]};
      end
    end
  end

  // stage 2: per-component products
  logic                            s2_v;
  logic signed [31:0]              s2_pdn [3];
  logic signed [31:0]              s2_pdr [3];
  logic signed [31:0]              s2_pdu [3];
  logic signed [rph_pkg::PO_W-1:0] s2_pon [3];
  logic signed [rph_pkg::PO_W-1:0] s2_por [3];
  logic signed [rph_pkg::PO_W-1:0] s2_pou [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (advance) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s2_pdn[i] <= 32'(s1_dir[i]) * 32'(nz[i]);
        s2_pdr[i] <= 32'(s1_dir[i]) * 32'(rx[i]);
        s2_pdu[i] <= 32'(s1_dir[i]) * 32'(uy[i]);
        s2_pon[i] <= rph_pkg::PO_W'(s1_otp[i]) * rph_pkg::PO_W'(nz[i]);
        s2_por[i] <= rph_pkg::PO_W'(s1_otp[i]) * rph_pkg::PO_W'(rx[i]);
        s2_pou[i] <= rph_pkg::PO_W'(s1_otp[i]) * rph_pkg::PO_W'(uy[i]);
      end
    end
  end

  // stage 3: dot sums, miss tests, divider operands
  logic signed [rph_pkg::DD_W-1:0]  ddn, ddr, ddu;
  logic signed [rph_pkg::DO_W-1:0]  don, dor, dou;
  logic signed [rph_pkg::NUM_W-1:0] num, neg_num;
  logic                             miss3;

  always_comb begin
    ddn = rph_pkg::DD_W'(s2_pdn[0]) + rph_pkg::DD_W'(s2_pdn[1]) + rph_pkg::DD_W'(s2_pdn[2]);
    ddr = rph_pkg::DD_W'(s2_pdr[0]) + rph_pkg::DD_W'(s2_pdr[1]) + rph_pkg::DD_W'(s2_pdr[2]);
    ddu = rph_pkg::DD_W'(s2_pdu[0]) + rph_pkg::DD_W'(s2_pdu[1]) + rph_pkg::DD_W'(s2_pdu[2]);
    don = rph_pkg::DO_W'(s2_pon[0]) + rph_pkg::DO_W'(s2_pon[1]) + rph_pkg::DO_W'(s2_pon[2]);
    dor = rph_pkg::DO_W'(s2_por[0]) + rph_pkg::DO_W'(s2_por[1]) + rph_pkg::DO_W'(s2_por[2]);
    dou = rph_pkg::DO_W'(s2_pou[0]) + rph_pkg::DO_W'(s2_pou[1]) + rph_pkg::DO_W'(s2_pou[2]);
    num = rph_pkg::NUM_W'(don)
        - $signed({{(rph_pkg::NUM_W-30){1'b0}}, panel_distance, 14'b0});
    neg_num = -num;
    miss3 = (ddn > rph_pkg::COS100) || (num > 0) || (half_width == '0) || (half_height == '0);
  end

  // distance divider, one quotient bit per stage, most significant first
  logic                              dv_v    [0:rph_pkg::Q_W];
  logic                              dv_miss [0:rph_pkg::Q_W];
  logic [rph_pkg::NUMER_W-1:0]       dv_rem  [0:rph_pkg::Q_W];
  logic [rph_pkg::DEN_W-1:0]         dv_den  [0:rph_pkg::Q_W];
  logic [rph_pkg::Q_W-1:0]           dv_q    [0:rph_pkg::Q_W];
  logic signed [rph_pkg::DD_W-1:0]   dv_ddr  [0:rph_pkg::Q_W];
  logic signed [rph_pkg::DD_W-1:0]   dv_ddu  [0:rph_pkg::Q_W];
  logic signed [rph_pkg::DO_W-1:0]   dv_dor  [0:rph_pkg::Q_W];
  logic signed [rph_pkg::DO_W-1:0]   dv_dou  [0:rph_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (advance) begin
      dv_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_miss[0] <= miss3;
      dv_rem[0]  <= {neg_num[rph_pkg::NEGN_W-1:0], 14'b0};
      dv_den[0]  <= rph_pkg::DEN_W'(-ddn);
      dv_q[0]    <= '0;
      dv_ddr[0]  <= ddr;
      dv_ddu[0]  <= ddu;
      dv_dor[0]  <= dor;
      dv_dou[0]  <= dou;
    end
  end

  for (genvar j = 1; j <= rph_pkg::Q_W; j++) begin : g_div
    localparam int K = rph_pkg::Q_W - j;
    logic [rph_pkg::CMP_W-1:0] dsh, rext;
    logic                      take;
    always_comb begin
      dsh  = rph_pkg::CMP_W'(dv_den[j-1]) << K;
      rext = rph_pkg::CMP_W'(dv_rem[j-1]);
      take = rext >= dsh;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j] <= 1'b0;
      end else if (advance) begin
        dv_v[j] <= dv_v[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        dv_rem[j]  <= take ? rph_pkg::NUMER_W'(rext - dsh) : dv_rem[j-1];
        dv_q[j]    <= dv_q[j-1] | (take ? (rph_pkg::Q_W'(1) << K) : '0);
        dv_den[j]  <= dv_den[j-1];
        dv_miss[j] <= dv_miss[j-1];
        dv_ddr[j]  <= dv_ddr[j-1];
        dv_ddu[j]  <= dv_ddu[j-1];
        dv_dor[j]  <= dv_dor[j-1];
        dv_dou[j]  <= dv_dou[j-1];
      end
    end
  end

  // stage m1: distance times direction-axis dots
  logic                              m1_v, m1_miss;
  logic signed [rph_pkg::PROD_W-1:0] m1_px, m1_py;
  logic signed [rph_pkg::DO_W-1:0]   m1_dor, m1_dou;
  logic [15:0]                       m1_dsat;
  logic [rph_pkg::Q_W-1:0]           dist_q;

  assign dist_q = dv_q[rph_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (advance) begin
      m1_v <= dv_v[rph_pkg::Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m1_px   <= rph_pkg::PROD_W'($signed({1'b0, dist_q}))
               * rph_pkg::PROD_W'(dv_ddr[rph_pkg::Q_W]);
      m1_py   <= rph_pkg::PROD_W'($signed({1'b0, dist_q}))
               * rph_pkg::PROD_W'(dv_ddu[rph_pkg::Q_W]);
      m1_dor  <= dv_dor[rph_pkg::Q_W];
      m1_dou  <= dv_dou[rph_pkg::Q_W];
      m1_miss <= dv_miss[rph_pkg::Q_W];
      m1_dsat <= (dist_q > rph_pkg::Q_W'(16'hFFFF)) ? 16'hFFFF : dist_q[15:0];
    end
  end

  // stage m2: floor shift, subtract offset dot, add half
  logic                            m2_v, m2_miss;
  logic signed [rph_pkg::AH_W-1:0] m2_ax, m2_ay;
  logic [15:0]                     m2_dsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (advance) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m2_ax   <= rph_pkg::AH_W'(m1_px >>> 14) - rph_pkg::AH_W'(m1_dor)
               + rph_pkg::AH_W'($signed({1'b0, h22_x}));
      m2_ay   <= rph_pkg::AH_W'(m1_py >>> 14) - rph_pkg::AH_W'(m1_dou)
               + rph_pkg::AH_W'($signed({1'b0, h22_y}));
      m2_miss <= m1_miss;
      m2_dsat <= m1_dsat;
    end
  end

  // stage m3: scale onto window size plus rounding half
  logic                           m3_v, m3_miss;
  logic signed [rph_pkg::N_W-1:0] m3_nx, m3_ny;
  logic [15:0]                    m3_dsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (advance) begin
      m3_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m3_nx   <= rph_pkg::N_W'(m2_ax) * rph_pkg::N_W'($signed({1'b0, win_w}))
               + rph_pkg::N_W'($signed({1'b0, h22_x}));
      m3_ny   <= rph_pkg::N_W'(m2_ay) * rph_pkg::N_W'($signed({1'b0, win_h}))
               + rph_pkg::N_W'($signed({1'b0, h22_y}));
      m3_miss <= m2_miss;
      m3_dsat <= m2_dsat;
    end
  end

  logic [rph_pkg::PIX_W-1:0] pix_x, pix_y;
  logic                      ok_x, ok_y;

  rph_pix_div u_div_x (
    .clk  (clk),
    .en   (advance),
    .n    (m3_nx),
    .half (half_width),
    .pix  (pix_x),
    .ok   (ok_x)
  );

  rph_pix_div u_div_y (
    .clk  (clk),
    .en   (advance),
    .n    (m3_ny),
    .half (half_height),
    .pix  (pix_y),
    .ok   (ok_y)
  );

  // item side data riding alongside the pixel dividers
  logic        pd_v    [0:rph_pkg::PIX_LAT];
  logic        pd_miss [0:rph_pkg::PIX_LAT];
  logic [15:0] pd_dsat [0:rph_pkg::PIX_LAT];

  always_comb begin
    pd_v[0]    = m3_v;
    pd_miss[0] = m3_miss;
    pd_dsat[0] = m3_dsat;
  end

  for (genvar j = 1; j <= rph_pkg::PIX_LAT; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        pd_v[j] <= 1'b0;
      end else if (advance) begin
        pd_v[j] <= pd_v[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        pd_miss[j] <= pd_miss[j-1];
        pd_dsat[j] <= pd_dsat[j-1];
      end
    end
  end

  logic hit_next;

  always_comb begin
    hit_next = !pd_miss[rph_pkg::PIX_LAT] && ok_x && ok_y
            && (pix_x < win_w) && (pix_y < win_h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pd_v[rph_pkg::PIX_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit          <= hit_next;
      pixel_x      <= hit_next ? (pix_x + win_x) : '0;
      pixel_y      <= hit_next ? (pix_y + win_y) : '0;
      hit_distance <= hit_next ? pd_dsat[rph_pkg::PIX_LAT] : '0;
    end
  end

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (pixel_x == '0 && pixel_y == '0 && hit_distance == '0))
    else $error("missed item carries nonzero payload");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_v[rph_pkg::Q_W] && !dv_miss[rph_pkg::Q_W])
      |-> (dv_rem[rph_pkg::Q_W] < rph_pkg::NUMER_W'(dv_den[rph_pkg::Q_W])))
    else $error("distance divider remainder not below divisor");

  a_hit_half: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (half_width != '0 && half_height != '0
                            && win_w != '0 && win_h != '0))
    else $error("hit reported with an empty panel or window");
`endif

endmodule

// File: rtl/rph_pix_div.sv
// rph_pix_div: pipelined restoring divider mapping a scaled coordinate to a pixel index
// depends on rph_pkg; one quotient bit per stage
module rph_pix_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rph_pkg::N_W-1:0]      n,
  input  logic [rph_pkg::HALF_W-1:0]          half,
  output logic [rph_pkg::PIX_W-1:0]           pix,
  output logic                                ok
);

  logic [rph_pkg::N_W-1:0]    mag;
  logic [rph_pkg::MAG_W-1:0]  mag_sh;
  logic                       ovf_in;

  logic [rph_pkg::PREM_W-1:0] rem [0:rph_pkg::PIX_W];
  logic [rph_pkg::PIX_W-1:0]  quo [0:rph_pkg::PIX_W];
  logic                       neg [0:rph_pkg::PIX_W];
  logic                       ovf [0:rph_pkg::PIX_W];

  // divisor is half * 2^15, so its low bits drop out of the magnitude
  always_comb begin
    mag    = n[rph_pkg::N_W-1] ? (-n) : n;
    mag_sh = mag[rph_pkg::N_W-1:15];
    ovf_in = mag_sh >= rph_pkg::MAG_W'({half, {rph_pkg::PIX_W{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= mag_sh[rph_pkg::PREM_W-1:0];
      quo[0] <= '0;
      neg[0] <= n[rph_pkg::N_W-1];
      ovf[0] <= ovf_in;
    end
  end

  for (genvar j = 1; j <= rph_pkg::PIX_W; j++) begin : g_step
    localparam int K = rph_pkg::PIX_W - j;
    logic [rph_pkg::PREM_W-1:0] dsh;
    logic                       take;
    always_comb begin
      dsh  = rph_pkg::PREM_W'(half) << K;
      take = rem[j-1] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= take ? (rem[j-1] - dsh) : rem[j-1];
        quo[j] <= quo[j-1] | (take ? (rph_pkg::PIX_W'(1) << K) : '0);
        neg[j] <= neg[j-1];
        ovf[j] <= ovf[j-1];
      end
    end
  end

  // a negative value gives pixel zero and is valid only when its magnitude is below one pixel
  always_comb begin
    pix = neg[rph_pkg::PIX_W] ? '0 : quo[rph_pkg::PIX_W];
    ok  = !ovf[rph_pkg::PIX_W] && !(neg[rph_pkg::PIX_W] && (quo[rph_pkg::PIX_W] != '0));
  end

endmodule

// File: sim/testbench.sv
// testbench for ray_panel_hit_test: rays against several panel poses, checked per item
// depends on rph_pkg and the ray_panel_hit_test rtl; self-contained otherwise
`timescale 1ns / 100ps

typedef struct {
  logic        hit;
  logic [11:0] px;
  logic [11:0] py;
  logic [15:0] distance;
} hit_result_t;

class hit_scoreboard;
  logic [47:0] right_ax, up_ax, normal_ax, pivot, window;
  logic [15:0] dist_cfg, half_w, half_h;
  hit_result_t pending[$];
  int          errors;

  function new();
    right_ax  = rph_pkg::RIGHT_RST;
    up_ax     = rph_pkg::UP_RST;
    normal_ax = rph_pkg::NORMAL_RST;
    pivot     = rph_pkg::PIVOT_RST;
    window    = rph_pkg::WINDOW_RST;
    dist_cfg  = rph_pkg::DIST_RST;
    half_w    = rph_pkg::HALF_W_RST;
    half_h    = rph_pkg::HALF_H_RST;
    errors    = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [47:0] val);
    case (idx)
      rph_pkg::REG_RIGHT:  right_ax  = val;
      rph_pkg::REG_UP:     up_ax     = val;
      rph_pkg::REG_NORMAL: normal_ax = val;
      rph_pkg::REG_PIVOT:  pivot     = val;
      rph_pkg::REG_DIST:   dist_cfg  = val[15:0];
      rph_pkg::REG_HALF_W: half_w    = val[15:0];
      rph_pkg::REG_HALF_H: half_h    = val[15:0];
      default:             window    = val;
    endcase
  endfunction

  function longint comp(logic [47:0] r, int k);
    logic signed [15:0] v;
    v = r[k*16 +: 16];
    return longint'(v);
  endfunction

  function longint dot_reg(longint a[3], logic [47:0] r);
    return a[0] * comp(r, 0) + a[1] * comp(r, 1) + a[2] * comp(r, 2);
  endfunction

  // maps a Q.22 coordinate onto the window, -1 when outside
  function longint scale_pix(longint raw, logic [15:0] half, logic [11:0] size);
    longint h22, n, p;
    h22 = longint'(half) * 16384;
    n = (raw + h22) * longint'(size) + h22;
    p = n / (2 * h22);
    if (p < 0 || p >= longint'(size)) return -1;
    return p;
  endfunction

  function void note_ray(logic [15:0] org[3], logic [15:0] dir[3]);
    longint d_v[3], offs[3], ddn, num, d, rawx, rawy, px, py;
    hit_result_t r;
    r = '{1'b0, 12'd0, 12'd0, 16'd0};
    for (int i = 0; i < 3; i++) begin
      d_v[i]  = longint'(signed'(dir[i]));
      offs[i] = comp(pivot, i) - longint'(signed'(org[i]));
    end
    ddn = dot_reg(d_v, normal_ax);
    num = dot_reg(offs, normal_ax) - longint'(dist_cfg) * 16384;
    if (ddn <= -64'sd46613280 && num <= 0 && half_w != 0 && half_h != 0) begin
      d = ((-num) * 16384) / (-ddn);
      rawx = ((d * dot_reg(d_v, right_ax)) >>> 14) - dot_reg(offs, right_ax);
      rawy = ((d * dot_reg(d_v, up_ax)) >>> 14) - dot_reg(offs, up_ax);
      px = scale_pix(rawx, half_w, window[35:24]);
      py = scale_pix(rawy, half_h, window[47:36]);
      if (px >= 0 && py >= 0) begin
        r.hit      = 1'b1;
        r.px       = px[11:0] + window[11:0];
        r.py       = py[11:0] + window[23:12];
        r.distance = d > 65535 ? 16'hFFFF : d[15:0];
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(hit_result_t got);
    hit_result_t e;
    if (pending.size() == 0) begin
      $error("result with no item outstanding");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.hit !== e.hit) begin
      $error("hit expected %0d got %0d", e.hit, got.hit); errors++;
    end
    if (got.px !== e.px) begin
      $error("pixel_x expected %0d got %0d", e.px, got.px); errors++;
    end
    if (got.py !== e.py) begin
      $error("pixel_y expected %0d got %0d", e.py, got.py); errors++;
    end
    if (got.distance !== e.distance) begin
      $error("hit_distance expected %0d got %0d", e.distance, got.distance); errors++;
    end
  endfunction
endclass

module testbench;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  logic hit;
  logic [rph_pkg::PIX_W-1:0] pixel_x, pixel_y;
  logic [15:0] hit_distance;
  logic cfg_valid, cfg_ready;
  logic [rph_pkg::IDX_W-1:0] cfg_index;
  logic [rph_pkg::REG_W-1:0] cfg_data;

  hit_scoreboard sb = new();
  int stall_mode, stall_left;

  ray_panel_hit_test u_dut (.*);

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result('{hit, pixel_x, pixel_y, hit_distance});

  // receiver stalls: switches between no stall, light, heavy and alternating
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(30, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic write_cfg(logic [rph_pkg::IDX_W-1:0] idx, logic [rph_pkg::REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // idle until every result is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  int burst_left;

  task automatic send_ray(logic [15:0] ox, oy, oz, dx, dy, dz);
    logic [15:0] o[3], d[3];
    o = '{ox, oy, oz};
    d = '{dx, dy, dz};
    in_valid <= 1'b1;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    do @(posedge clk); while (in_stall);
    sb.note_ray(o, d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 60)
                                             : $urandom_range(0, 8);
    end
  endtask

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // ray aimed back at the panel through a random lateral point
  task automatic send_aimed();
    longint a, ox, oy, c, sx, sy;
    logic [15:0] o[3], d[3];
    a  = $urandom_range(0, 2048);
    ox = $signed($urandom_range(0, 1600)) - 800;
    oy = $signed($urandom_range(0, 1600)) - 800;
    c  = $urandom_range(9000, 16384);
    sx = $signed($urandom_range(0, 8000)) - 4000;
    sy = $signed($urandom_range(0, 8000)) - 4000;
    for (int i = 0; i < 3; i++) begin
      o[i] = clamp16(sb.comp(sb.pivot, i) + ((a * sb.comp(sb.normal_ax, i)
             + ox * sb.comp(sb.right_ax, i) + oy * sb.comp(sb.up_ax, i)) >>> 14));
      d[i] = clamp16((-c * sb.comp(sb.normal_ax, i) + sx * sb.comp(sb.right_ax, i)
             + sy * sb.comp(sb.up_ax, i)) >>> 14);
    end
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endtask

  function automatic logic [15:0] rand_dir();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // axis-aligned frame: each axis one component of +/-1.0
  function automatic logic [47:0] unit_axis(int k, bit neg);
    logic [47:0] r;
    r = '0;
    r[k*16 +: 16] = neg ? 16'hC000 : 16'h4000;
    return r;
  endfunction

  task automatic random_pose();
    int p0, p1, p2;
    p0 = $urandom_range(0, 2);
    p1 = (p0 + $urandom_range(1, 2)) % 3;
    p2 = 3 - p0 - p1;
    write_cfg(rph_pkg::REG_RIGHT, unit_axis(p0, $urandom_range(0, 1)));
    write_cfg(rph_pkg::REG_UP, unit_axis(p1, $urandom_range(0, 1)));
    write_cfg(rph_pkg::REG_NORMAL, unit_axis(p2, $urandom_range(0, 1)));
    write_cfg(rph_pkg::REG_PIVOT, {16'($urandom_range(0, 4096) - 2048),
                                   16'($urandom_range(0, 4096) - 2048),
                                   16'($urandom_range(0, 4096) - 2048)});
    write_cfg(rph_pkg::REG_DIST, 48'($urandom_range(0, 2048)));
    write_cfg(rph_pkg::REG_HALF_W, 48'($urandom_range(64, 1024)));
    write_cfg(rph_pkg::REG_HALF_H, 48'($urandom_range(64, 1024)));
    write_cfg(rph_pkg::REG_WINDOW, {12'($urandom_range(1, 4095)),
                                    12'($urandom_range(1, 4095)),
                                    12'($urandom), 12'($urandom)});
  endtask

  initial begin
    rst = 1'b1;
    in_valid <= 1'b0; out_stall <= 1'b0; cfg_valid <= 1'b0;
    cfg_index <= rph_pkg::REG_RIGHT; cfg_data <= '0;
    origin_x <= '0; origin_y <= '0; origin_z <= '0;
    dir_x <= '0; dir_y <= '0; dir_z <= '0;
    stall_mode = 0; stall_left = 0; burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset pose, straight-on hit, edges, behind, grazing, extremes
    send_ray(0, 0, 0, 0, 0, 16'hC000);
    send_ray(16'h0200, 16'h0180, 0, 0, 0, 16'hC000);
    send_ray(16'hFE00, 16'hFE80, 0, 0, 0, 16'hC000);
    send_ray(0, 0, 16'hFC00, 0, 0, 16'hC000);
    send_ray(0, 0, 0, 16'h4000, 0, 0);
    send_ray(0, 0, 0, 0, 16'h3F00, 16'hF000);
    send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hC000, 16'hC000, 16'hC000);
    send_ray(16'h8000, 16'h8000, 16'h8000, 16'h4000, 16'h4000, 16'h4000);
    send_ray(0, 0, 16'h7FFF, 0, 0, 16'hC000);
    send_ray(0, 0, 16'h7FFF, 16'h0100, 0, 16'hF200);
    send_ray(16'h0010, 0, 16'h0100, 16'h0200, 16'h0100, 16'hC100);
    drain();
    // zero half size and zero window size both miss
    write_cfg(rph_pkg::REG_HALF_W, 0);
    send_ray(0, 0, 0, 0, 0, 16'hC000);
    drain();
    write_cfg(rph_pkg::REG_HALF_W, 16'hFFFF);
    write_cfg(rph_pkg::REG_HALF_H, 0);
    send_ray(0, 0, 0, 0, 0, 16'hC000);
    drain();
    write_cfg(rph_pkg::REG_HALF_H, 16'hFFFF);
    write_cfg(rph_pkg::REG_WINDOW, 48'hFFF_FFF_FFF_FFF);
    write_cfg(rph_pkg::REG_DIST, 16'hFFFF);
    send_ray(0, 0, 0, 0, 0, 16'hC000);
    send_ray(16'h8000, 0, 16'h8000, 0, 0, 16'hC000);
    send_ray(0, 0, 0, 16'h0400, 16'h0400, 16'hF000);
    drain();
    write_cfg(rph_pkg::REG_WINDOW, 48'h000_000_FFF_FFF);
    send_ray(0, 0, 0, 0, 0, 16'hC000);
    drain();
    write_cfg(rph_pkg::REG_RIGHT, 48'hFFFF_FFFF_FFFF);
    write_cfg(rph_pkg::REG_UP, 48'h7FFF_8000_7FFF);
    write_cfg(rph_pkg::REG_NORMAL, 48'h8000_8000_8000);
    write_cfg(rph_pkg::REG_PIVOT, 48'h7FFF_8000_7FFF);
    write_cfg(rph_pkg::REG_WINDOW, 48'h800_800_FFF_FFF);
    send_ray(16'h8000, 16'h7FFF, 16'h8000, 16'h4000, 16'h4000, 16'h4000);
    send_ray(0, 0, 0, 16'h4000, 16'hC000, 16'h4000);
    drain();

    // random phases over several poses, one with raw random axes
    for (int ph = 0; ph < 8; ph++) begin
      random_pose();
      if (ph == 6) begin
        write_cfg(rph_pkg::REG_RIGHT, 48'({$urandom, $urandom}));
        write_cfg(rph_pkg::REG_UP, 48'({$urandom, $urandom}));
        write_cfg(rph_pkg::REG_NORMAL, 48'({$urandom, $urandom}));
        write_cfg(rph_pkg::REG_PIVOT, 48'({$urandom, $urandom}));
        write_cfg(rph_pkg::REG_DIST, 48'($urandom));
      end
      for (int n = 0; n < 135; n++) begin
        if ($urandom_range(0, 9) < 7)
          send_aimed();
        else
          send_ray(16'($urandom), 16'($urandom), 16'($urandom),
                   rand_dir(), rand_dir(), rand_dir());
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
